[rtl/bhte_pkg.sv]
`timescale 1ns / 1ps

package bhte_pkg;

  // request command codes
  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_UPDATE = 2'd2,
    CMD_DELETE = 2'd3
  } cmd_e;

  // request sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_MOD,
    ST_READ,
    ST_EXEC
  } state_e;

  // one way of a bucket as held in the table memory
  typedef struct packed {
    logic        vld;
    logic [15:0] key;
    logic [31:0] val;
  } slot_t;

  // value returned by anything but a successful lookup
  localparam logic [31:0] READ_MISS = 32'hFFFF_FFFF;

endpackage

[rtl/bucketed_hash_table_engine.sv]
`timescale 1ns / 1ps

// Hash table of 16-bit keys and 32-bit values, NUM_BUCKETS buckets of WAYS_PER_BUCKET ways
// each, the bucket being key mod NUM_BUCKETS. Each request beat (lookup, insert, update,
// delete) gives exactly one result beat with ok, the looked-up value (all ones on a miss or
// for other commands), a bucket-full flag for inserts and the live entry count after the
// request. One request is handled at a time: the idle state takes a request beat, then the
// reciprocal multiply and the correction form the bucket index, the bucket row is read from
// the single-port table memory, and all ways are compared and the row is written back when
// changed. The result beat is registered out of the compare step. A new request can be
// accepted while the previous result still waits on the output; it then holds in the compare
// step until the output register frees up. After reset the table memory is swept clear one
// bucket row per cycle, and no request is accepted until every row has been cleared.
module bucketed_hash_table_engine #(
  parameter int NUM_BUCKETS     = 64,
  parameter int WAYS_PER_BUCKET = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         cmd_i,
  input  logic [15:0]        key_i,
  input  logic signed [31:0] data_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               ok_o,
  output logic signed [31:0] read_value_o,
  output logic               bucket_full_o,
  output logic [8:0]         entry_count_o
);
  import bhte_pkg::*;

  localparam int TOTAL_SLOTS = NUM_BUCKETS * WAYS_PER_BUCKET;
  localparam int BUCKET_W    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int WAY_W       = (WAYS_PER_BUCKET > 1) ? $clog2(WAYS_PER_BUCKET) : 1;
  localparam int CNT_W       = $clog2(TOTAL_SLOTS + 1);
  // floor(2^31 / NUM_BUCKETS): the quotient estimate is short by at most one
  localparam logic [31:0] RECIP = 32'((64'd1 << 31) / NUM_BUCKETS);
  localparam logic [28:0] NB_29 = 29'(NUM_BUCKETS);
  localparam logic [BUCKET_W-1:0] LAST_ROW = BUCKET_W'(NUM_BUCKETS - 1);

  // table memory: one row per bucket
  slot_t [WAYS_PER_BUCKET-1:0] slot_mem [NUM_BUCKETS];

  state_e                      state_q, state_d;
  logic [BUCKET_W-1:0]         clr_row_q, clr_row_d;
  cmd_e                        cmd_q;
  logic [15:0]                 key_q;
  logic [31:0]                 val_q;
  logic [15:0]                 quot_q;
  logic [BUCKET_W-1:0]         bucket_q;
  slot_t [WAYS_PER_BUCKET-1:0] rd_row_q;
  logic [CNT_W-1:0]            count_q, cnt_d;

  logic                        out_valid_q;
  logic                        ok_q, ok_d;
  logic [31:0]                 read_value_q, rval_d;
  logic                        bucket_full_q, full_d;
  logic [8:0]                  entry_count_q, entry_count_d;

  logic                        in_accept;
  logic                        out_free;
  logic                        load_out;
  logic                        mem_we, mem_re;
  logic [BUCKET_W-1:0]         mem_waddr;
  slot_t [WAYS_PER_BUCKET-1:0] mem_wdata;

  logic [47:0]                 hash_prod;
  logic [28:0]                 back_prod, rem_raw, rem_fix;

  logic                        hit, has_free, row_dirty;
  logic [WAY_W-1:0]            hit_way, free_way;
  slot_t [WAYS_PER_BUCKET-1:0] new_row;
  logic [CNT_W+8:0]            cnt_ext;

  // handshake
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // bucket index: key mod NUM_BUCKETS by reciprocal multiply and one correction
  assign hash_prod = 48'(key_q) * 48'(RECIP);
  assign back_prod = 29'(quot_q) * NB_29;
  assign rem_raw   = 29'(key_q) - back_prod;
  assign rem_fix   = (rem_raw >= NB_29) ? (rem_raw - NB_29) : rem_raw;

  // sequencer
  always_comb begin
    state_d   = state_q;
    clr_row_d = clr_row_q;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = bucket_q;
    mem_wdata = new_row;
    load_out  = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_row_q;
        mem_wdata = '0;
        clr_row_d = clr_row_q + BUCKET_W'(1);
        if (clr_row_q == LAST_ROW) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_HASH;
        end
      end
      ST_HASH: state_d = ST_MOD;
      ST_MOD:  state_d = ST_READ;
      ST_READ: begin
        mem_re  = 1'b1;
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) begin
          load_out = 1'b1;
          mem_we   = row_dirty;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_row_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_row_q <= clr_row_d;
    end
  end

  // way compare: first matching valid way, first free way
  always_comb begin
    hit      = 1'b0;
    hit_way  = '0;
    has_free = 1'b0;
    free_way = '0;
    for (int w = 0; w < WAYS_PER_BUCKET; w++) begin
      if (rd_row_q[w].vld) begin
        if (!hit && (rd_row_q[w].key == key_q)) begin
          hit     = 1'b1;
          hit_way = WAY_W'(w);
        end
      end else if (!has_free) begin
        has_free = 1'b1;
        free_way = WAY_W'(w);
      end
    end
  end

  // command execution on the read row
  always_comb begin
    new_row   = rd_row_q;
    row_dirty = 1'b0;
    ok_d      = 1'b0;
    rval_d    = READ_MISS;
    full_d    = 1'b0;
    cnt_d     = count_q;
    case (cmd_q)
      CMD_LOOKUP: begin
        if (hit) begin
          ok_d   = 1'b1;
          rval_d = rd_row_q[hit_way].val;
        end
      end
      CMD_INSERT: begin
        if (!hit) begin
          if (!has_free) begin
            full_d = 1'b1;
          end else begin
            new_row[free_way].vld = 1'b1;
            new_row[free_way].key = key_q;
            new_row[free_way].val = val_q;
            row_dirty             = 1'b1;
            cnt_d                 = count_q + CNT_W'(1);
            ok_d                  = 1'b1;
          end
        end
      end
      CMD_UPDATE: begin
        if (hit) begin
          new_row[hit_way].val = val_q;
          row_dirty            = 1'b1;
          ok_d                 = 1'b1;
        end
      end
      CMD_DELETE: begin
        if (hit) begin
          new_row[hit_way].vld = 1'b0;
          row_dirty            = 1'b1;
          if (count_q != '0) begin
            cnt_d = count_q - CNT_W'(1);
          end
          ok_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign cnt_ext       = (CNT_W + 9)'(cnt_d);
  assign entry_count_d = cnt_ext[8:0];

  // request payload and index pipeline
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q <= cmd_e'(cmd_i);
      key_q <= key_i;
      val_q <= data_value_i;
    end
    if (state_q == ST_HASH) begin
      quot_q <= hash_prod[46:31];
    end
    if (state_q == ST_MOD) begin
      bucket_q <= rem_fix[BUCKET_W-1:0];
    end
  end

  // table memory ports
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_row_q <= slot_mem[bucket_q];
    end
  end

  // live entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (load_out) begin
      count_q <= cnt_d;
    end
  end

  // result beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      ok_q          <= ok_d;
      read_value_q  <= rval_d;
      bucket_full_q <= full_d;
      entry_count_q <= entry_count_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign ok_o          = ok_q;
  assign read_value_o  = read_value_q;
  assign bucket_full_o = bucket_full_q;
  assign entry_count_o = entry_count_q;

  // checks
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> in_stall_o)
    else $error("request beat accepted during table clear");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TOTAL_SLOTS))
    else $error("live count exceeds slot count");

  a_mem_port_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("table read and write in the same cycle");

  a_result_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EXEC))
    else $error("result beat loaded outside execute");

  a_count_moves_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> $past(state_q == ST_EXEC))
    else $error("live count changed outside execute");

endmodule
